### hw/rtl/bsi_pkg.sv
// shared constants, mode codes and the control type of the bilinear smooth interpolator
package bsi_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 15;
  localparam int MODE_BITS         = 2;

  localparam logic [MODE_BITS-1:0] MODE_NEAREST      = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR       = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SMOOTHSTEP   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_SMOOTHERSTEP = 2'd3;

  typedef struct packed {
    logic load_sq;
    logic load_poly;
    logic load_out;
    logic out_valid;
  } shp_ctl_t;

endpackage

### hw/rtl/bsi_intf.sv
// request and result channel interfaces of the bilinear smooth interpolator
interface bsi_in_if #(
  parameter int SAMPLE_BITS   = bsi_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = bsi_pkg::FRACTION_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corner_upper_left;
  logic signed [SAMPLE_BITS-1:0] corner_upper_right;
  logic signed [SAMPLE_BITS-1:0] corner_lower_left;
  logic signed [SAMPLE_BITS-1:0] corner_lower_right;
  logic [FRACTION_BITS:0]        weight_x;
  logic [FRACTION_BITS:0]        weight_y;

  modport source (
    output valid, corner_upper_left, corner_upper_right, corner_lower_left,
           corner_lower_right, weight_x, weight_y,
    input  ready
  );
  modport sink (
    input  valid, corner_upper_left, corner_upper_right, corner_lower_left,
           corner_lower_right, weight_x, weight_y,
    output ready
  );
endinterface

interface bsi_out_if #(
  parameter int SAMPLE_BITS = bsi_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] blended_sample;

  modport source (output valid, blended_sample, input ready);
  modport sink (input valid, blended_sample, output ready);
endinterface

### hw/rtl/bsi_weight_shaper.sv
// three-stage weight shaper: saturate, square, cube and polynomial, clamp and mode select
module bsi_weight_shaper #(
  parameter int FRACTION_BITS = bsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  bsi_pkg::shp_ctl_t              ctl,
  input  logic [bsi_pkg::MODE_BITS-1:0]  mode,
  input  logic [FRACTION_BITS:0]         weight,
  output logic [FRACTION_BITS:0]         shaped
);

  localparam int WB = FRACTION_BITS + 1;
  localparam int PW = FRACTION_BITS + 6;
  localparam int MW = WB + 1 + PW;
  localparam int RW = MW - FRACTION_BITS;

  localparam logic [WB-1:0]        ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [WB-1:0]        HALF_W   = {2'b01, {(FRACTION_BITS-1){1'b0}}};
  localparam logic [2*WB-1:0]      HALF_2   = (2*WB)'(HALF_W);
  localparam logic [2*WB+1:0]      HALF_3   = (2*WB+2)'(HALF_W);
  localparam logic signed [MW-1:0] HALF_M   = MW'(HALF_W);
  localparam logic [WB+1:0]        THREE_ON = (WB+2)'(ONE) + (WB+2)'({ONE, 1'b0});
  localparam logic [PW-1:0]        TEN_ONE  = PW'(ONE) * PW'(10);
  localparam logic signed [RW-1:0] ONE_R    = RW'(ONE);

  // stage 2: saturate and square
  logic [WB-1:0]   w_sat;
  logic [2*WB-1:0] sq_sum;
  logic [WB-1:0]   w2;
  logic [WB-1:0]   sq2;

  assign w_sat  = (weight > ONE) ? ONE : weight;
  assign sq_sum = (2*WB)'(w_sat) * (2*WB)'(w_sat) + HALF_2;

  always_ff @(posedge clk) begin
    if (ctl.load_sq) begin
      w2  <= w_sat;
      sq2 <= sq_sum[FRACTION_BITS +: WB];
    end
  end

  // stage 3: smoothstep product, cube and smootherstep polynomial
  logic [WB+1:0]   fac3;
  logic [2*WB+1:0] ss_sum;
  logic [2*WB-1:0] cu_sum;
  logic [PW-1:0]   poly_next;
  logic [WB+1:0]   smooth3;
  logic [WB-1:0]   cu3;
  logic [PW-1:0]   poly3;
  logic [WB-1:0]   w3;
  logic            near3;

  assign fac3      = THREE_ON - (WB+2)'({w2, 1'b0});
  assign ss_sum    = (2*WB+2)'(sq2) * (2*WB+2)'(fac3) + HALF_3;
  assign cu_sum    = (2*WB)'(sq2) * (2*WB)'(w2) + HALF_2;
  assign poly_next = PW'(6) * PW'(sq2) - PW'(15) * PW'(w2) + TEN_ONE;

  always_ff @(posedge clk) begin
    if (ctl.load_poly) begin
      smooth3 <= ss_sum[FRACTION_BITS +: WB+2];
      cu3     <= cu_sum[FRACTION_BITS +: WB];
      poly3   <= poly_next;
      w3      <= w2;
      near3   <= (w2 >= HALF_W);
    end
  end

  // stage 4: smootherstep product, clamp and mode select
  logic signed [MW-1:0] sm_sum;
  logic signed [RW-1:0] sm_rnd;
  logic [WB-1:0]        sm_clamp;
  logic [WB-1:0]        ss_clamp;
  logic [WB-1:0]        shaped_next;

  assign sm_sum = MW'($signed({1'b0, cu3})) * MW'($signed(poly3)) + HALF_M;
  assign sm_rnd = sm_sum[MW-1:FRACTION_BITS];

  always_comb begin
    if (sm_rnd < 0) begin
      sm_clamp = '0;
    end else if (sm_rnd > ONE_R) begin
      sm_clamp = ONE;
    end else begin
      sm_clamp = sm_rnd[WB-1:0];
    end
    ss_clamp = (smooth3 > (WB+2)'(ONE)) ? ONE : smooth3[WB-1:0];
    unique case (mode)
      bsi_pkg::MODE_NEAREST:    shaped_next = near3 ? ONE : '0;
      bsi_pkg::MODE_LINEAR:     shaped_next = w3;
      bsi_pkg::MODE_SMOOTHSTEP: shaped_next = ss_clamp;
      default:                  shaped_next = sm_clamp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      shaped <= shaped_next;
    end
  end

  a_shaped_in_range: assert property (@(posedge clk) ctl.out_valid |-> (shaped <= ONE))
    else $error("shaped weight above one");

endmodule

### hw/rtl/bilinear_smooth_interpolator_core.sv
// bilinear interpolator with selectable weight shaping, six-stage pipeline
// throughput: one request per cycle while the result channel is not stalled; all six stages are fully pipelined
// stalls back up stage by stage and empty stages are filled, so bubbles collapse
// reset: rst clears all stage valid bits and sets the shaping mode to linear
module bilinear_smooth_interpolator_core #(
  parameter int SAMPLE_BITS   = bsi_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = bsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsi_pkg::MODE_BITS-1:0] cfg_wdata,
  bsi_in_if.sink                        corner_chan,
  bsi_out_if.source                     blend_chan
);

  localparam int WB = FRACTION_BITS + 1;
  localparam int PB = SAMPLE_BITS + WB + 1;
  localparam int SB = PB + 1;
  localparam int RB = SB - FRACTION_BITS;

  localparam logic [WB-1:0]        ONE    = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [SB-1:0] HALF_S = SB'({2'b01, {(FRACTION_BITS-1){1'b0}}});
  localparam logic signed [RB-1:0] SMAX   = RB'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
  localparam logic signed [RB-1:0] SMIN   = -SMAX - RB'(1);

  // shaping mode register
  logic [bsi_pkg::MODE_BITS-1:0] shaping_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      shaping_mode <= bsi_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      shaping_mode <= cfg_wdata;
    end
  end

  // stage valid and ready chain
  logic [6:1] v;
  logic [6:1] rdy;
  logic [6:1] v_prev;

  assign v_prev = {v[5:1], corner_chan.valid};

  always_comb begin
    rdy[6] = !v[6] || blend_chan.ready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) begin
          v[k] <= v_prev[k];
        end
      end
    end
  end

  assign corner_chan.ready = rdy[1];

  // stage 1: request capture
  logic signed [SAMPLE_BITS-1:0] ul1, ur1, ll1, lr1;
  logic [WB-1:0]                 wx1, wy1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ul1 <= corner_chan.corner_upper_left;
      ur1 <= corner_chan.corner_upper_right;
      ll1 <= corner_chan.corner_lower_left;
      lr1 <= corner_chan.corner_lower_right;
      wx1 <= corner_chan.weight_x;
      wy1 <= corner_chan.weight_y;
    end
  end

  // stages 2 to 4: corners ride along while the weights are shaped
  logic signed [SAMPLE_BITS-1:0] ul2, ur2, ll2, lr2;
  logic signed [SAMPLE_BITS-1:0] ul3, ur3, ll3, lr3;
  logic signed [SAMPLE_BITS-1:0] ul4, ur4, ll4, lr4;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ul2 <= ul1;
      ur2 <= ur1;
      ll2 <= ll1;
      lr2 <= lr1;
    end
    if (rdy[3]) begin
      ul3 <= ul2;
      ur3 <= ur2;
      ll3 <= ll2;
      lr3 <= lr2;
    end
    if (rdy[4]) begin
      ul4 <= ul3;
      ur4 <= ur3;
      ll4 <= ll3;
      lr4 <= lr3;
    end
  end

  bsi_pkg::shp_ctl_t shp_ctl;
  logic [WB-1:0]     wx4, wy4;

  assign shp_ctl.load_sq   = rdy[2];
  assign shp_ctl.load_poly = rdy[3];
  assign shp_ctl.load_out  = rdy[4];
  assign shp_ctl.out_valid = v[4];

  bsi_weight_shaper #(.FRACTION_BITS(FRACTION_BITS)) u_shape_x (
    .clk    (clk),
    .ctl    (shp_ctl),
    .mode   (shaping_mode),
    .weight (wx1),
    .shaped (wx4)
  );

  bsi_weight_shaper #(.FRACTION_BITS(FRACTION_BITS)) u_shape_y (
    .clk    (clk),
    .ctl    (shp_ctl),
    .mode   (shaping_mode),
    .weight (wy1),
    .shaped (wy4)
  );

  // stage 5: blend along y
  logic [WB-1:0]                 wy_inv;
  logic signed [PB-1:0]          p_ll, p_ul, p_lr, p_ur;
  logic signed [SB-1:0]          sum_left, sum_right;
  logic signed [SAMPLE_BITS-1:0] left5, right5;

  assign wy_inv    = ONE - wy4;
  assign p_ll      = PB'(ll4) * PB'($signed({1'b0, wy4}));
  assign p_ul      = PB'(ul4) * PB'($signed({1'b0, wy_inv}));
  assign p_lr      = PB'(lr4) * PB'($signed({1'b0, wy4}));
  assign p_ur      = PB'(ur4) * PB'($signed({1'b0, wy_inv}));
  assign sum_left  = SB'(p_ll) + SB'(p_ul) + HALF_S;
  assign sum_right = SB'(p_lr) + SB'(p_ur) + HALF_S;

  logic [WB-1:0] wx5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      left5  <= sum_left[FRACTION_BITS +: SAMPLE_BITS];
      right5 <= sum_right[FRACTION_BITS +: SAMPLE_BITS];
      wx5    <= wx4;
    end
  end

  // stage 6: blend along x, saturate, result register
  logic [WB-1:0]                 wx_inv;
  logic signed [PB-1:0]          p_left, p_right;
  logic signed [SB-1:0]          sum_out;
  logic signed [RB-1:0]          res_wide;
  logic signed [SAMPLE_BITS-1:0] res_next;
  logic signed [SAMPLE_BITS-1:0] res6;

  assign wx_inv   = ONE - wx5;
  assign p_left   = PB'(left5) * PB'($signed({1'b0, wx5}));
  assign p_right  = PB'(right5) * PB'($signed({1'b0, wx_inv}));
  assign sum_out  = SB'(p_left) + SB'(p_right) + HALF_S;
  assign res_wide = sum_out[SB-1:FRACTION_BITS];

  always_comb begin
    priority if (res_wide > SMAX) begin
      res_next = SMAX[SAMPLE_BITS-1:0];
    end else if (res_wide < SMIN) begin
      res_next = SMIN[SAMPLE_BITS-1:0];
    end else begin
      res_next = res_wide[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      res6 <= res_next;
    end
  end

  assign blend_chan.valid          = v[6];
  assign blend_chan.blended_sample = res6;

  a_reset_empties: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  a_bubble_accepts: assert property (@(posedge clk) disable iff (rst)
    (v != '1) |-> corner_chan.ready)
    else $error("request refused while a stage is empty");

  a_y_blend_holds: assert property (@(posedge clk) disable iff (rst)
    (v[5] && !rdy[5]) |=> (v[5] && $stable(left5) && $stable(right5)))
    else $error("stalled y blend lost");

  a_weights_in_range: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> (wx5 <= ONE))
    else $error("x weight above one at blend");

endmodule
